[hdl/rccd_pkg.sv]
// Shared types and constants for the rail channel change debouncer.
package rccd_pkg;

  localparam int CHAN_W = 7;
  localparam int BYTE_W = 8;
  localparam int BIT_W = 3;
  localparam int ADDR_W = CHAN_W + BIT_W;
  localparam logic [BYTE_W-1:0] FILTER_RESET = 8'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] accepted;
    logic [BYTE_W-1:0] candidate;
    logic [BYTE_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic [BYTE_W-1:0] mask;
    logic [BYTE_W-1:0] value;
    logic [CHAN_W-1:0] channel;
    logic              power;
  } event_group_t;

endpackage

[hdl/rccd_if.sv]
// Channel interfaces for samples, events and the filter register write.
interface rccd_in_if import rccd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] channel;
  logic [BYTE_W-1:0] sample;
  logic              track_power;
  modport source (output valid, channel, sample, track_power, input ready);
  modport sink (input valid, channel, sample, track_power, output ready);
endinterface

interface rccd_out_if import rccd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] accessory_address;
  logic              direction;
  logic              power;
  logic              last;
  modport source (output valid, accessory_address, direction, power, last, input ready);
  modport sink (input valid, accessory_address, direction, power, last, output ready);
endinterface

interface rccd_cfg_if import rccd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] debounce_len;
  modport source (output valid, debounce_len, input ready);
  modport sink (input valid, debounce_len, output ready);
endinterface

[hdl/rccd_state.sv]
// Per-channel state memory with read, debounce update and write back.
module rccd_state import rccd_pkg::*; #(
  parameter int CHANNELS = 104,
  parameter int EMIT_CHANNEL_LIMIT = 99
) (
  input  logic              clk,
  input  logic              rst,
  rccd_in_if.sink           samples,
  input  logic [BYTE_W-1:0] debounce_len,
  output logic              grp_valid,
  input  logic              grp_ready,
  output event_group_t      grp
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [8:0] CHAN_LIM = 9'(CHANNELS);
  localparam logic [8:0] EMIT_LIM = 9'(EMIT_CHANNEL_LIMIT);

  entry_t             mem [CHANNELS];
  logic [CHANNELS-1:0] vld;

  logic              s1_valid;
  logic [IDX_W-1:0]  s1_idx;
  logic [CHAN_W-1:0] s1_ch;
  logic [BYTE_W-1:0] s1_sample;
  logic              s1_pwr;
  entry_t            rd_data;
  logic              rd_vld;

  logic              wb_valid;
  logic [IDX_W-1:0]  wb_idx;
  entry_t            wb_data;

  logic              in_take;
  logic              in_range;
  logic [IDX_W-1:0]  in_idx;
  logic              s1_adv;
  entry_t            cur;
  entry_t            upd;
  logic              accept;
  logic [BYTE_W-1:0] cnt_inc;

  assign in_idx   = IDX_W'(samples.channel);
  assign in_range = {2'b00, samples.channel} < CHAN_LIM;
  assign in_take  = samples.valid && samples.ready;
  assign samples.ready = !s1_valid || s1_adv;

  always_comb begin
    if (wb_valid && wb_idx == s1_idx) begin
      cur = wb_data;
    end else if (rd_vld) begin
      cur = rd_data;
    end else begin
      cur = '0;
    end
    cnt_inc = cur.count + 8'd1;
    upd = cur;
    accept = 1'b0;
    if (debounce_len == '0) begin
      if (cur.accepted != s1_sample) begin
        upd.accepted = s1_sample;
        accept = 1'b1;
      end
    end else if (cur.accepted == s1_sample) begin
      upd.count = '0;
    end else if (cur.count == '0) begin
      upd.count = cnt_inc;
      upd.candidate = s1_sample;
    end else if (cur.candidate == s1_sample) begin
      if (cnt_inc >= debounce_len) begin
        upd.accepted = s1_sample;
        upd.count = '0;
        accept = 1'b1;
      end else begin
        upd.count = cnt_inc;
      end
    end else begin
      upd.count = 8'd1;
      upd.candidate = s1_sample;
    end
  end

  assign grp_valid = s1_valid && accept && ({2'b00, s1_ch} <= EMIT_LIM);
  assign s1_adv = s1_valid && (!grp_valid || grp_ready);
  assign grp.mask    = cur.accepted ^ s1_sample;
  assign grp.value   = s1_sample;
  assign grp.channel = s1_ch;
  assign grp.power   = s1_pwr;

  always_ff @(posedge clk) begin
    if (in_take) begin
      rd_data <= mem[in_idx];
      rd_vld  <= vld[in_idx];
      s1_idx  <= in_idx;
      s1_ch   <= samples.channel;
      s1_sample <= samples.sample;
      s1_pwr  <= samples.track_power;
    end
    if (s1_adv) begin
      mem[s1_idx] <= upd;
      wb_idx  <= s1_idx;
      wb_data <= upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      wb_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (s1_adv) begin
        vld[s1_idx] <= 1'b1;
        wb_valid    <= 1'b1;
      end
      if (in_take) begin
        s1_valid <= in_range;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

endmodule

[hdl/rccd_emit.sv]
// Event serialiser: one transaction per changed bit, ascending bit order.
module rccd_emit import rccd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         grp_valid,
  output logic         grp_ready,
  input  event_group_t grp,
  rccd_out_if.source   events
);

  logic              em_valid;
  event_group_t      em;
  logic [BIT_W-1:0]  pos;
  logic [BYTE_W-1:0] low_bit;
  logic              last;

  always_comb begin
    pos = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      if (em.mask[i]) begin
        pos = BIT_W'(i);
      end
    end
  end

  assign low_bit = em.mask & (~em.mask + 8'd1);
  assign last    = (em.mask & ~low_bit) == '0;

  assign events.valid             = em_valid;
  assign events.accessory_address = {em.channel, pos};
  assign events.direction         = em.value[pos];
  assign events.power             = em.power;
  assign events.last              = last;

  assign grp_ready = !em_valid || (events.ready && last);

  always_ff @(posedge clk) begin
    if (grp_valid && grp_ready) begin
      em <= grp;
    end else if (em_valid && events.ready) begin
      em.mask <= em.mask & ~low_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      em_valid <= 1'b0;
    end else if (grp_valid && grp_ready) begin
      em_valid <= 1'b1;
    end else if (em_valid && events.ready && last) begin
      em_valid <= 1'b0;
    end
  end

endmodule

[hdl/rail_channel_change_debouncer.sv]
// Rail channel change debouncer top level.
// Path: a sample is registered in the state stage, and its events leave from the serialiser's register.
// Throughput: one sample per cycle when it emits nothing, else it waits for the event
//   serialiser to take its group (up to eight events); state lives in a 104-entry memory.
// Reset: synchronous; clears the per-entry valid flags (no clearing pass) and
//   sets the debounce length to 2.
module rail_channel_change_debouncer import rccd_pkg::*; #(
  parameter int CHANNELS = 104,
  parameter int EMIT_CHANNEL_LIMIT = 99
) (
  input  logic      clk,
  input  logic      rst,
  rccd_in_if.sink   samples,
  rccd_cfg_if.sink  cfg,
  rccd_out_if.source events
);

  logic [BYTE_W-1:0] debounce_len;
  logic              grp_valid;
  logic              grp_ready;
  event_group_t      grp;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_len <= FILTER_RESET;
    end else if (cfg.valid && cfg.ready) begin
      debounce_len <= cfg.debounce_len;
    end
  end

  rccd_state #(
    .CHANNELS           (CHANNELS),
    .EMIT_CHANNEL_LIMIT (EMIT_CHANNEL_LIMIT)
  ) u_state (
    .clk          (clk),
    .rst          (rst),
    .samples      (samples),
    .debounce_len (debounce_len),
    .grp_valid    (grp_valid),
    .grp_ready    (grp_ready),
    .grp          (grp)
  );

  rccd_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (grp_valid),
    .grp_ready (grp_ready),
    .grp       (grp),
    .events    (events)
  );

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the rail channel change debouncer against a local model.
module tb_top;
  import rccd_pkg::*;

  localparam int CHANNELS = 104;
  localparam int EMIT_LIMIT = 99;
  localparam logic [BYTE_W-1:0] FILTER_OFF = 8'd0;
  localparam logic [BYTE_W-1:0] FILTER_MAX = 8'd255;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              dir;
    logic              pwr;
    logic              last;
  } bit_event_t;

  logic clk = 1'b0;
  logic rst;

  rccd_in_if  samples_if ();
  rccd_cfg_if cfg_if ();
  rccd_out_if events_if ();

  rail_channel_change_debouncer u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .cfg     (cfg_if),
    .events  (events_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [BYTE_W-1:0] held_byte [CHANNELS];
  logic [BYTE_W-1:0] pending_byte [CHANNELS];
  logic [BYTE_W-1:0] agree_cnt [CHANNELS];
  logic [BYTE_W-1:0] filter_setting = FILTER_RESET;
  bit_event_t        expected_events [$];

  bit idling = 1'b1;
  int items_sent = 0;
  int events_seen = 0;
  int errors = 0;

  function automatic void queue_bit_events(input logic [CHAN_W-1:0] ch,
                                           input logic [BYTE_W-1:0] old,
                                           input logic [BYTE_W-1:0] newv,
                                           input logic pwr);
    logic [BYTE_W-1:0] diff;
    int top;
    bit_event_t ev;
    diff = old ^ newv;
    if (ch > EMIT_LIMIT) return;
    top = -1;
    for (int b = 0; b < BYTE_W; b++) if (diff[b]) top = b;
    for (int b = 0; b < BYTE_W; b++) begin
      if (diff[b]) begin
        ev.addr = {ch, b[BIT_W-1:0]};
        ev.dir  = newv[b];
        ev.pwr  = pwr;
        ev.last = (b == top);
        expected_events.push_back(ev);
      end
    end
  endfunction

  function automatic void predict_sample(input logic [CHAN_W-1:0] ch,
                                         input logic [BYTE_W-1:0] smp,
                                         input logic pwr);
    logic [BYTE_W-1:0] old;
    logic [BYTE_W-1:0] prev;
    if (ch >= CHANNELS) return;
    old = held_byte[ch];
    if (filter_setting == FILTER_OFF) begin
      if (old != smp) begin
        held_byte[ch] = smp;
        queue_bit_events(ch, old, smp, pwr);
      end
      return;
    end
    if (old == smp) begin
      agree_cnt[ch] = '0;
      return;
    end
    prev = agree_cnt[ch];
    agree_cnt[ch] = prev + 8'd1;
    if (prev == 0) begin
      pending_byte[ch] = smp;
    end else if (pending_byte[ch] == smp) begin
      if (agree_cnt[ch] >= filter_setting) begin
        held_byte[ch] = smp;
        agree_cnt[ch] = '0;
        queue_bit_events(ch, old, smp, pwr);
      end
    end else begin
      agree_cnt[ch] = 8'd1;
      pending_byte[ch] = smp;
    end
  endfunction

  task automatic send_sample(input int ch, input int smp, input bit pwr);
    int gap;
    if (idling && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 14);
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid       <= 1'b1;
    samples_if.channel     <= ch[CHAN_W-1:0];
    samples_if.sample      <= smp[BYTE_W-1:0];
    samples_if.track_power <= pwr;
    do @(posedge clk); while (!samples_if.ready);
    predict_sample(ch[CHAN_W-1:0], smp[BYTE_W-1:0], pwr);
    if (ch < CHANNELS) items_sent++;
  endtask

  task automatic drain_events();
    samples_if.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_filter(input logic [BYTE_W-1:0] value);
    drain_events();
    cfg_if.valid        <= 1'b1;
    cfg_if.debounce_len <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    filter_setting = value;
  endtask

  function automatic int pick_channel();
    if ($urandom_range(0, 9) == 0) return $urandom_range(EMIT_LIMIT + 1, 127);
    return $urandom_range(0, EMIT_LIMIT);
  endfunction

  always @(posedge clk) begin
    bit_event_t got;
    bit_event_t want;
    if (!rst && events_if.valid && events_if.ready) begin
      got = '{events_if.accessory_address, events_if.direction, events_if.power,
              events_if.last};
      events_seen++;
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected event addr=%0d dir=%0b pwr=%0b last=%0b", $time,
                 got.addr, got.dir, got.pwr, got.last);
      end else begin
        want = expected_events.pop_front();
        if (got.addr !== want.addr || got.dir !== want.dir || got.pwr !== want.pwr ||
            got.last !== want.last) begin
          errors++;
          $display("%0t: event mismatch: expected addr=%0d dir=%0b pwr=%0b last=%0b,",
                   $time, want.addr, want.dir, want.pwr, want.last,
                   " got addr=%0d dir=%0b pwr=%0b last=%0b",
                   got.addr, got.dir, got.pwr, got.last);
        end
      end
    end
  end

  initial begin
    int gap;
    events_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idling && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 14);
        events_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      events_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // first acceptance at reset filter, top emitting channel, ignored and silent channels
  task automatic test_reset_filter();
    send_sample(0, 8'hFF, 1'b1);
    send_sample(0, 8'hFF, 1'b1);
    send_sample(EMIT_LIMIT, 8'h80, 1'b0);
    send_sample(EMIT_LIMIT, 8'h80, 1'b0);
    send_sample(EMIT_LIMIT, 8'h80, 1'b1);
    send_sample(103, 8'h55, 1'b1);
    send_sample(103, 8'h55, 1'b0);
    send_sample(127, 8'hAA, 1'b1);
    send_sample(CHANNELS, 8'hAA, 1'b0);
  endtask

  // interrupted candidate, count cleared by the accepted value, count kept across bypass
  task automatic test_candidate_rules();
    send_sample(5, 8'h0F, 1'b1);
    send_sample(5, 8'hF0, 1'b1);
    send_sample(5, 8'hF0, 1'b0);
    send_sample(6, 8'h01, 1'b1);
    send_sample(6, 8'h00, 1'b1);
    send_sample(6, 8'h01, 1'b0);
    send_sample(6, 8'h01, 1'b1);
    send_sample(8, 8'h77, 1'b1);
  endtask

  task automatic test_low_filters();
    write_filter(8'd1);
    send_sample(7, 8'h3C, 1'b1);
    send_sample(7, 8'h3C, 1'b0);
    write_filter(FILTER_OFF);
    send_sample(0, 8'h00, 1'b0);
    send_sample(100, 8'h11, 1'b1);
    send_sample(8, 8'h33, 1'b1);
    write_filter(FILTER_RESET);
    send_sample(8, 8'h77, 1'b1);
  endtask

  task automatic run_traffic(input int n_items);
    int target;
    int ch;
    int reps;
    int v;
    int k;
    target = items_sent + n_items;
    while (items_sent < target) begin
      ch = pick_channel();
      reps = (filter_setting == FILTER_OFF) ? 1 : (filter_setting < 2 ? 2 : filter_setting);
      v = $urandom_range(0, 255);
      case ($urandom_range(0, 9)) inside
        [0:5]: begin
          repeat (reps) send_sample(ch, v, $urandom_range(0, 1));
        end
        6: send_sample(ch, v, $urandom_range(0, 1));
        7: begin
          k = $urandom_range(1, reps);
          repeat (k) send_sample(ch, v, $urandom_range(0, 1));
          send_sample(ch, v ^ $urandom_range(1, 255), $urandom_range(0, 1));
        end
        8: send_sample(ch, ch < CHANNELS ? held_byte[ch] : v, $urandom_range(0, 1));
        default: begin
          if (ch < CHANNELS) v = held_byte[ch] ^ (1 << $urandom_range(0, 7));
          repeat (reps) send_sample(ch, v, $urandom_range(0, 1));
        end
      endcase
      if ($urandom_range(0, 39) == 0) drain_events();
    end
  endtask

  task automatic test_random_traffic();
    write_filter(FILTER_RESET);
    run_traffic(18);
    write_filter(FILTER_OFF);
    run_traffic(18);
    write_filter(8'd1);
    run_traffic(16);
    write_filter(8'd3);
    run_traffic(16);
    write_filter(8'd7);
    run_traffic(16);
  endtask

  task automatic test_long_filter();
    int ch;
    int v;
    write_filter(FILTER_MAX);
    ch = $urandom_range(0, EMIT_LIMIT);
    v = held_byte[ch] ^ $urandom_range(1, 255);
    repeat (FILTER_MAX) send_sample(ch, v, $urandom_range(0, 1));
    send_sample(ch, v ^ 8'h01, 1'b1);
  endtask

  task automatic test_quiet_tail();
    write_filter(FILTER_RESET);
    idling = 1'b0;
    run_traffic(25);
  endtask

  initial begin
    for (int i = 0; i < CHANNELS; i++) begin
      held_byte[i] = '0;
      pending_byte[i] = '0;
      agree_cnt[i] = '0;
    end
    rst                    <= 1'b1;
    samples_if.valid       <= 1'b0;
    samples_if.channel     <= '0;
    samples_if.sample      <= '0;
    samples_if.track_power <= 1'b0;
    cfg_if.valid           <= 1'b0;
    cfg_if.debounce_len    <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_filter();
    test_candidate_rules();
    test_low_filters();
    test_random_traffic();
    test_long_filter();
    test_quiet_tail();

    samples_if.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d samples on live channels with filter settings 0, 1, 2, 3, 7 and 255,",
             items_sent);
    $display("checked %0d bit events, %0d mismatches.", events_seen, errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
